@@ src/cfbp_pkg.sv @@
// Package with the shared types, codes and constants of the chunked fixed block pool.
package cfbp_pkg;

  localparam int CHUNK_W = 3;
  localparam int OFS_W = 20;
  localparam int BPC_W = 8;
  localparam int BSZ_W = 13;
  localparam int IDX_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS = OFS_W;
  localparam int LINKS_PER_CHUNK = 256;

  localparam logic [BPC_W-1:0] BPC_RESET = 8'd255;
  localparam logic [BSZ_W-1:0] BSZ_RESET = 13'd8;
  localparam logic [BSZ_W-1:0] BSZ_LIMIT = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_CHUNK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [CHUNK_W-1:0]  chunk_in;
    logic [OFS_W-1:0]    offset_in;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CHUNK_W-1:0]  chunk_out;
    logic [OFS_W-1:0]    offset_out;
    logic [IDX_W-1:0]    free_left;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_NEW,
    S_SETUP,
    S_POP_RD,
    S_POP_WB,
    S_REL_CHK,
    S_DIV,
    S_REL_WB
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SEL_CLR,
    OP_SEL_INC,
    OP_OOM,
    OP_NEW_INIT,
    OP_SETUP_STEP,
    OP_SETUP_LAST,
    OP_POP_RD,
    OP_POP_WB,
    OP_REL_UNUSED,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_REL_WB
  } dp_op_t;

  typedef struct packed {
    logic cur_ok;
    logic sel_free_nz;
    logic used_zero;
    logic sel_last;
    logic pool_full;
    logic setup_last;
    logic unused;
    logic div_last;
  } dp_status_t;

endpackage

@@ src/chunked_fixed_block_pool.sv @@
// Top level of the chunked fixed block pool allocator.
// Allocate from the current chunk when it has a free block; on a miss the chunks in use are scanned
// in order and, if none has one, a new chunk is set up by linking its blocks before the pop.
// Out of memory is answered after the scan when no new chunk can be set up; a release runs the
// offset divider, or is answered as bad when the chunk is not in use.
// One transaction at a time; the next start is taken in the cycle the result is shown.
// Reset clears counts, heads, the current chunk and loads 255 blocks of 8 bytes, not link memory.
module chunked_fixed_block_pool #(
  parameter int NUM_CHUNKS = 8,
  parameter int MAX_BLOCKS = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  cfbp_pkg::in_t                    in_data,
  output logic                             out_valid,
  output cfbp_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [cfbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cfbp_pkg::dp_op_t     op;
  cfbp_pkg::dp_status_t status;

  cfbp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .kind   (in_data.kind),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  cfbp_dp #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .op        (op),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == cfbp_pkg::ST_OK ||
                   out_data.status == cfbp_pkg::ST_OOM ||
                   out_data.status == cfbp_pkg::ST_BAD))
    else $error("result carries an undefined status code");

  a_oom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == cfbp_pkg::ST_OOM) |->
      (out_data.chunk_out == '0 && out_data.offset_out == '0 && out_data.free_left == '0))
    else $error("out of memory result carries nonzero fields");

endmodule

@@ src/cfbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/cfbp_ctrl.sv @@
// Controller state machine that sequences allocate and release transactions.
module cfbp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   kind,
  input  cfbp_pkg::dp_status_t   status,
  output cfbp_pkg::dp_op_t       op,
  output logic                   busy
);

  cfbp_pkg::state_t state_r;
  cfbp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfbp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfbp_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (kind == cfbp_pkg::KIND_RELEASE) ? cfbp_pkg::S_REL_CHK
                                                       : cfbp_pkg::S_CHECK;
        end
      end
      cfbp_pkg::S_CHECK: begin
        state_nxt = status.cur_ok ? cfbp_pkg::S_POP_RD : cfbp_pkg::S_SCAN;
      end
      cfbp_pkg::S_SCAN: begin
        if (status.used_zero) begin
          state_nxt = cfbp_pkg::S_NEW;
        end else if (status.sel_free_nz) begin
          state_nxt = cfbp_pkg::S_POP_RD;
        end else if (status.sel_last) begin
          state_nxt = cfbp_pkg::S_NEW;
        end
      end
      cfbp_pkg::S_NEW: begin
        state_nxt = status.pool_full ? cfbp_pkg::S_IDLE : cfbp_pkg::S_SETUP;
      end
      cfbp_pkg::S_SETUP: begin
        if (status.setup_last) begin
          state_nxt = cfbp_pkg::S_POP_RD;
        end
      end
      cfbp_pkg::S_POP_RD:  state_nxt = cfbp_pkg::S_POP_WB;
      cfbp_pkg::S_POP_WB:  state_nxt = cfbp_pkg::S_IDLE;
      cfbp_pkg::S_REL_CHK: begin
        state_nxt = status.unused ? cfbp_pkg::S_IDLE : cfbp_pkg::S_DIV;
      end
      cfbp_pkg::S_DIV: begin
        if (status.div_last) begin
          state_nxt = cfbp_pkg::S_REL_WB;
        end
      end
      cfbp_pkg::S_REL_WB:  state_nxt = cfbp_pkg::S_IDLE;
      default:             state_nxt = cfbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op = cfbp_pkg::OP_NONE;
    busy = 1'b1;
    case (state_r)
      cfbp_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op = cfbp_pkg::OP_CAPTURE;
        end
      end
      cfbp_pkg::S_CHECK: begin
        if (!status.cur_ok) begin
          op = cfbp_pkg::OP_SEL_CLR;
        end
      end
      cfbp_pkg::S_SCAN: begin
        if (!status.used_zero && !status.sel_free_nz && !status.sel_last) begin
          op = cfbp_pkg::OP_SEL_INC;
        end
      end
      cfbp_pkg::S_NEW: begin
        op = status.pool_full ? cfbp_pkg::OP_OOM : cfbp_pkg::OP_NEW_INIT;
      end
      cfbp_pkg::S_SETUP: begin
        op = status.setup_last ? cfbp_pkg::OP_SETUP_LAST : cfbp_pkg::OP_SETUP_STEP;
      end
      cfbp_pkg::S_POP_RD:  op = cfbp_pkg::OP_POP_RD;
      cfbp_pkg::S_POP_WB:  op = cfbp_pkg::OP_POP_WB;
      cfbp_pkg::S_REL_CHK: begin
        op = status.unused ? cfbp_pkg::OP_REL_UNUSED : cfbp_pkg::OP_DIV_INIT;
      end
      cfbp_pkg::S_DIV:     op = cfbp_pkg::OP_DIV_STEP;
      cfbp_pkg::S_REL_WB:  op = cfbp_pkg::OP_REL_WB;
      default: begin
        op = cfbp_pkg::OP_NONE;
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/cfbp_dp.sv @@
// Datapath with the pool bookkeeping, link memory, offset divider and result register.
module cfbp_dp #(
  parameter int NUM_CHUNKS = 8,
  parameter int MAX_BLOCKS = 255
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [cfbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfbp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  cfbp_pkg::in_t                         in_data,
  input  cfbp_pkg::dp_op_t                      op,
  output cfbp_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  output cfbp_pkg::out_t                        out_data
);

  localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int UW = $clog2(NUM_CHUNKS + 1);
  localparam int LINK_DEPTH = NUM_CHUNKS * cfbp_pkg::LINKS_PER_CHUNK;
  localparam int LINK_AW = $clog2(LINK_DEPTH);
  localparam int IW = cfbp_pkg::IDX_W;
  localparam int OW = cfbp_pkg::OFS_W;
  localparam int SW = cfbp_pkg::BSZ_W;

  logic [IW-1:0] head_r [NUM_CHUNKS];
  logic [IW-1:0] head_nxt [NUM_CHUNKS];
  logic [IW-1:0] free_r [NUM_CHUNKS];
  logic [IW-1:0] free_nxt [NUM_CHUNKS];
  logic [UW-1:0] used_r, used_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [cfbp_pkg::BPC_W-1:0] bpc_r, bpc_nxt;
  logic [SW-1:0] bsz_r, bsz_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [cfbp_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [CW-1:0] sel_r, sel_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  cfbp_pkg::out_t out_r, out_nxt;

  logic [IW-1:0] eff_n;
  logic [SW-1:0] eff_sz;
  logic [IW-1:0] sel_free;
  logic [IW-1:0] sel_head;
  logic [SW:0]   div_shift;
  logic [SW:0]   div_diff;
  logic          div_ge;
  logic [OW:0]   prod;
  logic          rel_bad;

  logic               link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [IW-1:0]      link_wdata;
  logic [LINK_AW-1:0] link_raddr;
  logic [IW-1:0]      link_rdata;

  cfbp_ram #(
    .WIDTH (IW),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign eff_n = (bpc_r > IW'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : bpc_r;
  assign eff_sz = (bsz_r == '0) ? SW'(1) :
                  (bsz_r > cfbp_pkg::BSZ_LIMIT) ? cfbp_pkg::BSZ_LIMIT : bsz_r;

  assign sel_free = free_r[sel_r];
  assign sel_head = head_r[sel_r];
  assign link_raddr = LINK_AW'({sel_r, sel_head});

  assign div_shift = {rem_r, quo_r[OW-1]};
  assign div_diff = div_shift - {1'b0, eff_sz};
  assign div_ge = div_shift >= {1'b0, eff_sz};

  assign prod = {{(OW + 1 - IW){1'b0}}, idx_r} * {{(OW + 1 - SW){1'b0}}, eff_sz};

  assign rel_bad = (rem_r != '0) || (quo_r >= OW'(eff_n)) || (sel_free >= eff_n);

  always_comb begin
    status.cur_ok = cur_valid_r && (sel_free != '0);
    status.sel_free_nz = sel_free != '0;
    status.used_zero = used_r == '0;
    status.sel_last = UW'(sel_r) == (used_r - UW'(1));
    status.pool_full = (used_r >= UW'(NUM_CHUNKS)) || (eff_n == '0);
    status.setup_last = cnt_r == (eff_n - IW'(1));
    status.unused = 32'(chunk_r) >= 32'(used_r);
    status.div_last = cnt_r == IW'(cfbp_pkg::DIV_STEPS - 1);
  end

  always_comb begin
    head_nxt = head_r;
    free_nxt = free_r;
    used_nxt = used_r;
    cur_nxt = cur_r;
    cur_valid_nxt = cur_valid_r;
    bpc_nxt = bpc_r;
    bsz_nxt = bsz_r;
    out_valid_nxt = 1'b0;
    chunk_nxt = chunk_r;
    sel_nxt = sel_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    out_nxt = out_r;
    link_we = 1'b0;
    link_waddr = LINK_AW'({sel_r, cnt_r});
    link_wdata = cnt_r + IW'(1);

    if (cfg_we) begin
      if (cfg_index == cfbp_pkg::CFG_BLOCKS_PER_CHUNK) begin
        bpc_nxt = cfg_data[cfbp_pkg::BPC_W-1:0];
      end else if (cfg_index == cfbp_pkg::CFG_BLOCK_SIZE) begin
        bsz_nxt = cfg_data[SW-1:0];
      end
    end

    case (op)
      cfbp_pkg::OP_CAPTURE: begin
        chunk_nxt = in_data.chunk_in;
        quo_nxt = in_data.offset_in;
        sel_nxt = cur_r;
      end
      cfbp_pkg::OP_SEL_CLR: sel_nxt = '0;
      cfbp_pkg::OP_SEL_INC: sel_nxt = sel_r + CW'(1);
      cfbp_pkg::OP_OOM: begin
        out_valid_nxt = 1'b1;
        out_nxt.status = cfbp_pkg::ST_OOM;
        out_nxt.chunk_out = '0;
        out_nxt.offset_out = '0;
        out_nxt.free_left = '0;
      end
      cfbp_pkg::OP_NEW_INIT: begin
        sel_nxt = CW'(used_r);
        cnt_nxt = '0;
      end
      cfbp_pkg::OP_SETUP_STEP: begin
        link_we = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
      end
      cfbp_pkg::OP_SETUP_LAST: begin
        link_we = 1'b1;
        head_nxt[sel_r] = '0;
        free_nxt[sel_r] = eff_n;
        used_nxt = used_r + UW'(1);
      end
      cfbp_pkg::OP_POP_RD: begin
        idx_nxt = sel_head;
        cur_nxt = sel_r;
        cur_valid_nxt = 1'b1;
      end
      cfbp_pkg::OP_POP_WB: begin
        head_nxt[sel_r] = link_rdata;
        free_nxt[sel_r] = sel_free - IW'(1);
        out_valid_nxt = 1'b1;
        out_nxt.status = cfbp_pkg::ST_OK;
        out_nxt.chunk_out = cfbp_pkg::CHUNK_W'(sel_r);
        out_nxt.offset_out = prod[OW-1:0];
        out_nxt.free_left = sel_free - IW'(1);
      end
      cfbp_pkg::OP_REL_UNUSED: begin
        out_valid_nxt = 1'b1;
        out_nxt.status = cfbp_pkg::ST_BAD;
        out_nxt.chunk_out = chunk_r;
        out_nxt.offset_out = '0;
        out_nxt.free_left = '0;
      end
      cfbp_pkg::OP_DIV_INIT: begin
        sel_nxt = CW'(chunk_r);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      cfbp_pkg::OP_DIV_STEP: begin
        rem_nxt = div_ge ? div_diff[SW-1:0] : div_shift[SW-1:0];
        quo_nxt = {quo_r[OW-2:0], div_ge};
        cnt_nxt = cnt_r + IW'(1);
      end
      cfbp_pkg::OP_REL_WB: begin
        out_valid_nxt = 1'b1;
        out_nxt.chunk_out = chunk_r;
        out_nxt.offset_out = '0;
        if (rel_bad) begin
          out_nxt.status = cfbp_pkg::ST_BAD;
          out_nxt.free_left = sel_free;
        end else begin
          link_we = 1'b1;
          link_waddr = LINK_AW'({sel_r, quo_r[IW-1:0]});
          link_wdata = sel_head;
          head_nxt[sel_r] = quo_r[IW-1:0];
          free_nxt[sel_r] = sel_free + IW'(1);
          out_nxt.status = cfbp_pkg::ST_OK;
          out_nxt.free_left = sel_free + IW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        head_r[i] <= '0;
        free_r[i] <= '0;
      end
      used_r <= '0;
      cur_r <= '0;
      cur_valid_r <= 1'b0;
      bpc_r <= cfbp_pkg::BPC_RESET;
      bsz_r <= cfbp_pkg::BSZ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      free_r <= free_nxt;
      used_r <= used_nxt;
      cur_r <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      bpc_r <= bpc_nxt;
      bsz_r <= bsz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chunk_r <= chunk_nxt;
    sel_r <= sel_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
